### rtl/tgmc_pkg.sv
// Shared types and constants for the touch gesture mode controller.
// Holds item structs, mode and cause codes, register indexes and reset values.
// No dependencies.
package tgmc_pkg;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_CONFIG   = 2'd1,
    MODE_SETTINGS = 2'd2
  } mode_t;

  // Reason for a mode change on this item
  typedef enum logic [2:0] {
    CAUSE_NONE            = 3'd0,
    CAUSE_LONG_PRESS      = 3'd1,
    CAUSE_SWIPE           = 3'd2,
    CAUSE_REMOTE_EXIT     = 3'd3,
    CAUSE_IDLE_TIMEOUT    = 3'd4,
    CAUSE_SETTINGS_CLOSED = 3'd5
  } cause_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLACK_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_BAND       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MIN_DROP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWIPE_MAX_TIME = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_CANCEL    = 3'd6;

  // Register reset values
  localparam logic [15:0] HOLD_TIME_RST      = 16'd800;
  localparam logic [15:0] SLACK_TIME_RST     = 16'd100;
  localparam logic [31:0] IDLE_TIMEOUT_RST   = 32'd300000;
  localparam logic [10:0] TOP_BAND_RST       = 11'd48;
  localparam logic [10:0] SWIPE_MIN_DROP_RST = 11'd70;
  localparam logic [15:0] SWIPE_MAX_TIME_RST = 16'd2500;
  localparam logic [10:0] MOVE_CANCEL_RST    = 11'd25;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] hold_time_ms;
    logic [15:0] slack_time_ms;
    logic [31:0] idle_timeout_ms;
    logic [10:0] top_band_height;
    logic [10:0] swipe_min_drop;
    logic [15:0] swipe_max_time_ms;
    logic [10:0] move_cancel_px;
  } cfg_regs_t;

  // One touch sample
  typedef struct packed {
    logic              touched;
    logic              press_edge;
    logic signed [11:0] touch_y;
    logic signed [11:0] move_x;
    logic signed [11:0] move_y;
    logic [31:0]       now_ms;
    logic              exit_flag;
    logic              activity_pulse;
    logic              settings_close;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [1:0] mode_now;
    logic [2:0] change_cause;
    logic       tone_pulse;
    logic       clear_exit;
  } out_item_t;

endpackage

### rtl/tgmc_core.sv
// Gesture detectors and mode machine: state registers and one-pass next-state logic.
// Depends on tgmc_pkg. Advances its state on each step_en.
module tgmc_core
  import tgmc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  cfg_regs_t cfg,
  input  in_item_t  item,
  output out_item_t res
);

  // State
  mode_t                 mode_r, mode_nxt;
  logic                  press_active_r, press_active_nxt;
  logic                  hold_fired_r, hold_fired_nxt;
  logic [TIME_WIDTH-1:0] press_start_r, press_start_nxt;
  logic [TIME_WIDTH-1:0] last_touch_r, last_touch_nxt;
  logic                  swipe_fired_r, swipe_fired_nxt;
  logic                  swipe_in_band_r, swipe_in_band_nxt;
  logic [11:0]           swipe_row_r, swipe_row_nxt;
  logic [TIME_WIDTH-1:0] swipe_start_r, swipe_start_nxt;
  logic                  act_valid_r, act_valid_nxt;
  logic [TIME_WIDTH-1:0] act_time_r, act_time_nxt;

  // Intermediate
  logic [TIME_WIDTH-1:0] now_t;
  mode_t                 mode_pre;
  logic                  act_valid_pre;
  logic [TIME_WIDTH-1:0] act_time_pre;
  logic                  close_hit;
  logic                  run;
  logic [TIME_WIDTH-1:0] gap_d, hold_d, swipe_d, idle_d;
  logic                  gap_long, restart, cancel;
  logic [11:0]           abs_x, abs_y;
  logic                  lp_fire, sw_fire, sw_run;
  logic signed [12:0]    dy;
  cause_t                cause;
  logic                  tone, clr;

  assign now_t = item.now_ms[TIME_WIDTH-1:0];

  // Activity pulse and settings close come before the detectors
  always_comb begin
    act_valid_pre = act_valid_r;
    act_time_pre  = act_time_r;
    if (item.activity_pulse) begin
      act_valid_pre = 1'b1;
      act_time_pre  = now_t;
    end
    close_hit = item.settings_close && (mode_r == MODE_SETTINGS);
    mode_pre  = close_hit ? MODE_NORMAL : mode_r;
    if (close_hit) begin
      act_valid_pre = 1'b0;
    end
    run = (mode_pre != MODE_SETTINGS);
  end

  // Long-press detector
  assign abs_x = item.move_x[11] ? 12'(-item.move_x) : item.move_x;
  assign abs_y = item.move_y[11] ? 12'(-item.move_y) : item.move_y;
  assign gap_d = now_t - last_touch_r;

  always_comb begin
    gap_long         = 32'(gap_d) > 32'(cfg.slack_time_ms);
    restart          = !press_active_r || gap_long;
    cancel           = (abs_x > {1'b0, cfg.move_cancel_px}) ||
                       (abs_y > {1'b0, cfg.move_cancel_px});
    press_active_nxt = press_active_r;
    hold_fired_nxt   = hold_fired_r;
    press_start_nxt  = press_start_r;
    last_touch_nxt   = last_touch_r;
    lp_fire          = 1'b0;
    hold_d           = '0;
    if (run) begin
      if (item.touched) begin
        if (restart) begin
          press_active_nxt = 1'b1;
          press_start_nxt  = now_t;
          hold_fired_nxt   = 1'b0;
        end
        last_touch_nxt = now_t;
        if (cancel) begin
          press_active_nxt = 1'b0;
          hold_fired_nxt   = 1'b0;
        end
      end else if (press_active_r && gap_long) begin
        press_active_nxt = 1'b0;
        hold_fired_nxt   = 1'b0;
      end
      hold_d = now_t - press_start_nxt;
      if (!(item.touched && cancel) && press_active_nxt && !hold_fired_nxt &&
          (32'(hold_d) >= 32'(cfg.hold_time_ms))) begin
        lp_fire        = 1'b1;
        hold_fired_nxt = 1'b1;
      end
    end
  end

  // Swipe-down detector, only in normal mode and when no long press fired
  assign sw_run = run && !lp_fire && (mode_pre == MODE_NORMAL);

  always_comb begin
    swipe_fired_nxt   = swipe_fired_r;
    swipe_in_band_nxt = swipe_in_band_r;
    swipe_row_nxt     = swipe_row_r;
    swipe_start_nxt   = swipe_start_r;
    sw_fire           = 1'b0;
    swipe_d           = '0;
    dy                = '0;
    if (sw_run) begin
      if (!item.touched) begin
        swipe_fired_nxt   = 1'b0;
        swipe_in_band_nxt = 1'b0;
      end else begin
        if (item.press_edge) begin
          swipe_row_nxt     = item.touch_y;
          swipe_start_nxt   = now_t;
          swipe_fired_nxt   = 1'b0;
          swipe_in_band_nxt = !item.touch_y[11] &&
                              (item.touch_y[10:0] < cfg.top_band_height);
        end
        swipe_d = now_t - swipe_start_nxt;
        dy      = {item.touch_y[11], item.touch_y} - {swipe_row_nxt[11], swipe_row_nxt};
        if (!swipe_fired_nxt && swipe_in_band_nxt &&
            (32'(swipe_d) <= 32'(cfg.swipe_max_time_ms)) &&
            (dy >= signed'({2'b00, cfg.swipe_min_drop}))) begin
          sw_fire         = 1'b1;
          swipe_fired_nxt = 1'b1;
        end
      end
    end
  end

  // Mode next state
  assign idle_d = now_t - act_time_pre;

  always_comb begin
    mode_nxt      = mode_pre;
    act_valid_nxt = act_valid_pre;
    act_time_nxt  = act_time_pre;
    cause         = close_hit ? CAUSE_SETTINGS_CLOSED : CAUSE_NONE;
    tone          = 1'b0;
    clr           = 1'b0;
    if (run) begin
      priority if (lp_fire) begin
        tone  = 1'b1;
        cause = CAUSE_LONG_PRESS;
        if (mode_pre == MODE_CONFIG) begin
          mode_nxt      = MODE_NORMAL;
          act_valid_nxt = 1'b0;
        end else begin
          mode_nxt      = MODE_CONFIG;
          act_time_nxt  = now_t;
          act_valid_nxt = 1'b1;
        end
      end else if (sw_fire) begin
        tone          = 1'b1;
        cause         = CAUSE_SWIPE;
        mode_nxt      = MODE_SETTINGS;
        act_valid_nxt = 1'b0;
      end else if (mode_pre == MODE_CONFIG && item.exit_flag) begin
        clr           = 1'b1;
        cause         = CAUSE_REMOTE_EXIT;
        mode_nxt      = MODE_NORMAL;
        act_valid_nxt = 1'b0;
      end else if (mode_pre == MODE_CONFIG && act_valid_pre &&
                   (32'(idle_d) > cfg.idle_timeout_ms)) begin
        cause         = CAUSE_IDLE_TIMEOUT;
        mode_nxt      = MODE_NORMAL;
        act_valid_nxt = 1'b0;
      end else begin
        cause = cause;
      end
    end
  end

  // Result for this item
  always_comb begin
    res.mode_now     = mode_nxt;
    res.change_cause = cause;
    res.tone_pulse   = tone;
    res.clear_exit   = clr;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_NORMAL;
      press_active_r  <= 1'b0;
      hold_fired_r    <= 1'b0;
      press_start_r   <= '0;
      last_touch_r    <= '0;
      swipe_fired_r   <= 1'b0;
      swipe_in_band_r <= 1'b0;
      swipe_row_r     <= '0;
      swipe_start_r   <= '0;
      act_valid_r     <= 1'b0;
      act_time_r      <= '0;
    end else if (step_en) begin
      mode_r          <= mode_nxt;
      press_active_r  <= press_active_nxt;
      hold_fired_r    <= hold_fired_nxt;
      press_start_r   <= press_start_nxt;
      last_touch_r    <= last_touch_nxt;
      swipe_fired_r   <= swipe_fired_nxt;
      swipe_in_band_r <= swipe_in_band_nxt;
      swipe_row_r     <= swipe_row_nxt;
      swipe_start_r   <= swipe_start_nxt;
      act_valid_r     <= act_valid_nxt;
      act_time_r      <= act_time_nxt;
    end
  end

  // Checks
  // a settings close on the same item drops to normal before the swipe runs
  a_swipe_from_normal: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.change_cause == CAUSE_SWIPE |->
      mode_r == MODE_NORMAL || (mode_r == MODE_SETTINGS && item.settings_close))
    else $error("swipe fired outside normal mode");

  a_swipe_enters_settings: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.change_cause == CAUSE_SWIPE |=> mode_r == MODE_SETTINGS)
    else $error("swipe did not enter settings mode");

  a_clear_needs_config: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.clear_exit |-> mode_r == MODE_CONFIG && item.exit_flag)
    else $error("exit flag cleared outside config mode");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(mode_r) && $stable(act_valid_r))
    else $error("state moved without an item");

  a_settings_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && mode_r == MODE_SETTINGS && !item.settings_close
    |=> $stable(press_active_r) && $stable(swipe_fired_r))
    else $error("detector state changed in settings mode");

endmodule

### rtl/touch_gesture_mode_controller.sv
// Touch gesture mode controller: top level with handshake stages and config registers.
// Depends on tgmc_pkg and tgmc_core.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one touch sample per item.
//   Result channel out_valid/out_stall/out_item returns exactly one result per
//   sample: the mode after the sample, the change cause, the tone pulse and
//   the exit-flag clear.
//   Config port cfg_we/cfg_index/cfg_wdata writes one register per cycle;
//   write only while no sample is in flight.
// Timing:
//   An item accepted into the input register runs through the detector and mode
//   logic in one pass and lands in the output register once the output stage
//   can advance, that is when no result is held there by out_stall.
//   Throughput is one item per cycle while out_stall is low; the mode state
//   is updated in the same pass, so back-to-back samples see each other's effect.
// Stall:
//   While out_stall holds a pending result, the input register holds too and
//   in_stall rises once that register is occupied; nothing is dropped.
// Reset:
//   rst_n (sync, active low) empties both stages, puts the block in normal
//   mode with all detectors idle and loads the register defaults.
module touch_gesture_mode_controller
  import tgmc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  // Configuration port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  cfg_regs_t cfg_r;
  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  logic      out_vld_r;
  out_item_t res;
  logic      advance;
  logic      in_take;

  // Handshake control
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_time_ms      <= HOLD_TIME_RST;
      cfg_r.slack_time_ms     <= SLACK_TIME_RST;
      cfg_r.idle_timeout_ms   <= IDLE_TIMEOUT_RST;
      cfg_r.top_band_height   <= TOP_BAND_RST;
      cfg_r.swipe_min_drop    <= SWIPE_MIN_DROP_RST;
      cfg_r.swipe_max_time_ms <= SWIPE_MAX_TIME_RST;
      cfg_r.move_cancel_px    <= MOVE_CANCEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_TIME:      cfg_r.hold_time_ms      <= cfg_wdata[15:0];
        REG_SLACK_TIME:     cfg_r.slack_time_ms     <= cfg_wdata[15:0];
        REG_IDLE_TIMEOUT:   cfg_r.idle_timeout_ms   <= cfg_wdata;
        REG_TOP_BAND:       cfg_r.top_band_height   <= cfg_wdata[10:0];
        REG_SWIPE_MIN_DROP: cfg_r.swipe_min_drop    <= cfg_wdata[10:0];
        REG_SWIPE_MAX_TIME: cfg_r.swipe_max_time_ms <= cfg_wdata[15:0];
        REG_MOVE_CANCEL:    cfg_r.move_cancel_px    <= cfg_wdata[10:0];
        default:            cfg_r                   <= cfg_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_item;
    end
  end

  // Detectors and mode machine
  tgmc_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_vld_r && advance),
    .cfg     (cfg_r),
    .item    (in_r),
    .res     (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

### bench/touch_gesture_mode_controller_tb.sv
// Self-checking bench for touch_gesture_mode_controller: gesture, swipe and timeout traffic
// against a cycle-free model of the mode machine, with random idling on both channels.
// Depends on tgmc_pkg and the touch_gesture_mode_controller RTL.
module touch_gesture_mode_controller_tb;
  import tgmc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HOLD_TIME;
  logic [31:0]          cfg_wdata = '0;

  // Stimulus bookkeeping
  in_item_t    touch_samples[$];
  out_item_t   due_results[$];
  int          n_offered = 0;
  int          n_accepted = 0;
  int          n_queued = 0;
  int          n_errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [31:0] t_ms = '0;

  // Model copy of the configuration registers
  logic [15:0] hold_ms      = HOLD_TIME_RST;
  logic [15:0] gap_lim_ms   = SLACK_TIME_RST;
  logic [31:0] idle_ms      = IDLE_TIMEOUT_RST;
  int          band_px      = int'(TOP_BAND_RST);
  int          drop_px      = int'(SWIPE_MIN_DROP_RST);
  logic [15:0] swipe_win_ms = SWIPE_MAX_TIME_RST;
  int          cancel_px    = int'(MOVE_CANCEL_RST);

  // Model copy of the mode machine state
  mode_t       mode_q = MODE_NORMAL;
  logic        press_on = 1'b0;
  logic        hold_done = 1'b0;
  logic        swipe_done = 1'b0;
  logic        swipe_armed = 1'b0;
  logic        act_seen = 1'b0;
  logic [31:0] press_t0 = '0;
  logic [31:0] last_touch_ms = '0;
  logic [31:0] swipe_t0 = '0;
  logic [31:0] act_time = '0;
  int          swipe_row0 = 0;

  touch_gesture_mode_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Mode machine model: one touch sample in, one result out
  function automatic out_item_t predict_mode_step(input in_item_t s);
    out_item_t   r;
    logic [31:0] now;
    int          y;
    int          mx;
    int          my;
    logic        hold_hit;
    logic        swipe_hit;
    now = s.now_ms;
    y = $signed(s.touch_y);
    mx = $signed(s.move_x);
    my = $signed(s.move_y);
    r.change_cause = CAUSE_NONE;
    r.tone_pulse = 1'b0;
    r.clear_exit = 1'b0;
    hold_hit = 1'b0;
    swipe_hit = 1'b0;

    // side pulses land before the tick logic
    if (s.activity_pulse) begin
      act_time = now;
      act_seen = 1'b1;
    end
    if (s.settings_close && mode_q == MODE_SETTINGS) begin
      mode_q = MODE_NORMAL;
      act_seen = 1'b0;
      r.change_cause = CAUSE_SETTINGS_CLOSED;
    end

    if (mode_q != MODE_SETTINGS) begin
      // long press, bridged over dropouts up to the slack window
      if (s.touched) begin
        if (!press_on || now - last_touch_ms > gap_lim_ms) begin
          press_on = 1'b1;
          press_t0 = now;
          hold_done = 1'b0;
        end
        last_touch_ms = now;
        if ((mx < 0 ? -mx : mx) > cancel_px || (my < 0 ? -my : my) > cancel_px) begin
          press_on = 1'b0;
          hold_done = 1'b0;
        end
      end else if (press_on && now - last_touch_ms > gap_lim_ms) begin
        press_on = 1'b0;
        hold_done = 1'b0;
      end
      if (press_on && !hold_done && now - press_t0 >= hold_ms) begin
        hold_done = 1'b1;
        hold_hit = 1'b1;
      end

      if (hold_hit) begin
        r.tone_pulse = 1'b1;
        r.change_cause = CAUSE_LONG_PRESS;
        if (mode_q == MODE_CONFIG) begin
          mode_q = MODE_NORMAL;
          act_seen = 1'b0;
        end else begin
          mode_q = MODE_CONFIG;
          act_time = now;
          act_seen = 1'b1;
        end
      end else if (mode_q == MODE_NORMAL) begin
        // swipe down from the top band, once per press
        if (!s.touched) begin
          swipe_done = 1'b0;
          swipe_armed = 1'b0;
        end else begin
          if (s.press_edge) begin
            swipe_row0 = y;
            swipe_t0 = now;
            swipe_done = 1'b0;
            swipe_armed = (y >= 0 && y < band_px);
          end
          if (!swipe_done && swipe_armed && now - swipe_t0 <= swipe_win_ms &&
              y - swipe_row0 >= drop_px) begin
            swipe_done = 1'b1;
            swipe_hit = 1'b1;
          end
        end
        if (swipe_hit) begin
          r.tone_pulse = 1'b1;
          r.change_cause = CAUSE_SWIPE;
          mode_q = MODE_SETTINGS;
          act_seen = 1'b0;
        end
      end else if (mode_q == MODE_CONFIG) begin
        if (s.exit_flag) begin
          r.clear_exit = 1'b1;
          r.change_cause = CAUSE_REMOTE_EXIT;
          mode_q = MODE_NORMAL;
          act_seen = 1'b0;
        end else if (act_seen && now - act_time > idle_ms) begin
          r.change_cause = CAUSE_IDLE_TIMEOUT;
          mode_q = MODE_NORMAL;
          act_seen = 1'b0;
        end
      end
    end
    r.mode_now = mode_q;
    return r;
  endfunction

  function automatic logic rare(input int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic logic [11:0] to12(input int v);
    int c;
    c = (v > 2047) ? 2047 : (v < -2048) ? -2048 : v;
    return c[11:0];
  endfunction

  task automatic note_failure(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("%s", msg);
  endtask

  // Register write; the model copy is masked to the register width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_HOLD_TIME:      hold_ms = data[15:0];
      REG_SLACK_TIME:     gap_lim_ms = data[15:0];
      REG_IDLE_TIMEOUT:   idle_ms = data;
      REG_TOP_BAND:       band_px = int'(data[10:0]);
      REG_SWIPE_MIN_DROP: drop_px = int'(data[10:0]);
      REG_SWIPE_MAX_TIME: swipe_win_ms = data[15:0];
      REG_MOVE_CANCEL:    cancel_px = int'(data[10:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write all seven registers, with junk above the width of each register narrower than 32 bits
  task automatic apply_setting(input logic [31:0] hold, input logic [31:0] slack,
                               input logic [31:0] idle, input logic [31:0] band,
                               input logic [31:0] drop, input logic [31:0] win,
                               input logic [31:0] cancel);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_HOLD_TIME, {junk[31:16], hold[15:0]});
    write_reg(REG_SLACK_TIME, {junk[15:0], slack[15:0]});
    write_reg(REG_IDLE_TIMEOUT, idle);
    junk = $urandom;
    write_reg(REG_TOP_BAND, {junk[31:11], band[10:0]});
    write_reg(REG_SWIPE_MIN_DROP, {junk[20:0], drop[10:0]});
    write_reg(REG_SWIPE_MAX_TIME, {junk[31:16], win[15:0]});
    write_reg(REG_MOVE_CANCEL, {junk[25:5], cancel[10:0]});
  endtask

  // Queue one sample, dt ms after the previous one
  task automatic push_sample(input logic tch, input logic pe, input int y, input int mx,
                             input int my, input logic [31:0] dt, input logic ex,
                             input logic act, input logic cls);
    in_item_t s;
    t_ms = t_ms + dt;
    s.touched = tch;
    s.press_edge = pe;
    s.touch_y = to12(y);
    s.move_x = to12(mx);
    s.move_y = to12(my);
    s.now_ms = t_ms;
    s.exit_flag = ex;
    s.activity_pulse = act;
    s.settings_close = cls;
    touch_samples.push_back(s);
    n_queued++;
  endtask

  // Held press with dropouts, gaps past the slack window and stray movement
  task automatic gen_long_press();
    int          steps;
    int          mx;
    int          my;
    int          y;
    logic        tch;
    logic [31:0] dt;
    y = $urandom_range(0, 1500);
    push_sample(1'b1, 1'b1, y, 0, 0, $urandom_range(1, 500), rare(16), rare(8), rare(8));
    steps = $urandom_range(2, 12);
    for (int i = 0; i < steps; i++) begin
      tch = !rare(6);
      dt = rare(8) ? gap_lim_ms + $urandom_range(1, 50)
                   : $urandom_range(gap_lim_ms / 2, gap_lim_ms);
      if (rare(8)) begin
        mx = cancel_px + $urandom_range(1, 20);
        my = $urandom_range(0, cancel_px);
      end else begin
        mx = $urandom_range(0, cancel_px);
        my = $urandom_range(0, cancel_px);
      end
      if ($urandom_range(0, 1)) mx = -mx;
      if ($urandom_range(0, 1)) my = -my;
      push_sample(tch, 1'b0, y, mx, my, dt, rare(16), rare(8), rare(12));
    end
    push_sample(1'b0, 1'b0, y, 0, 0, $urandom_range(0, 300), rare(16), rare(8), rare(8));
  endtask

  // Downward drag that starts mostly inside the top band
  task automatic gen_swipe();
    int          steps;
    int          y;
    logic [31:0] dt;
    if (band_px > 0 && !rare(6)) y = $urandom_range(0, band_px - 1);
    else y = $urandom_range(0, 200);
    push_sample(1'b1, 1'b1, y, $urandom_range(0, 10), 0, $urandom_range(1, 400),
                rare(16), rare(8), rare(8));
    steps = $urandom_range(2, 6);
    for (int i = 0; i < steps; i++) begin
      y = y + $urandom_range(0, drop_px / 2 + 10);
      dt = rare(8) ? swipe_win_ms + $urandom_range(1, 50)
                   : $urandom_range(0, swipe_win_ms / 4);
      push_sample(1'b1, 1'b0, y, $urandom_range(0, 30), $urandom_range(0, 30), dt,
                  rare(16), rare(8), rare(4));
    end
    push_sample(1'b0, 1'b0, y, 0, 0, $urandom_range(0, 200), rare(16), rare(8), rare(3));
  endtask

  // Untouched samples around the idle timeout, with remote exits and closes
  task automatic gen_idle();
    int          steps;
    logic [31:0] dt;
    steps = $urandom_range(1, 4);
    for (int i = 0; i < steps; i++) begin
      dt = rare(2) ? idle_ms + $urandom_range(1, 100) : $urandom_range(0, idle_ms / 2);
      push_sample(1'b0, 1'b0, $urandom_range(0, 400), 0, 0, dt, rare(4), rare(3), rare(3));
    end
  endtask

  // Fully random sample; the timestamp sometimes jumps anywhere
  task automatic gen_noise();
    logic [95:0] raw;
    in_item_t    s;
    raw = {$urandom, $urandom, $urandom};
    s = raw[$bits(in_item_t)-1:0];
    if (rare(4)) t_ms = s.now_ms;
    else begin
      t_ms = t_ms + $urandom_range(0, 200);
      s.now_ms = t_ms;
    end
    touch_samples.push_back(s);
    n_queued++;
  endtask

  // Wait until every queued item has been taken and answered
  task automatic drain();
    while (!(touch_samples.size() == 0 && n_offered == n_accepted &&
             due_results.size() == 0))
      @(negedge clk);
  endtask

  // Sender: a stalled item stays put until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && n_accepted != n_offered) begin
      in_valid <= 1'b1;
    end else if (touch_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_item <= touch_samples.pop_front();
      in_valid <= 1'b1;
      n_offered++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_left <= LONG_HOLD;
      hold_served <= hold_asked;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
  end

  // Predict on each accepted sample, check each accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due_results.push_back(predict_mode_step(in_item));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          note_failure($sformatf("unexpected result mode=%0d cause=%0d tone=%0d clr=%0d",
                                 out_item.mode_now, out_item.change_cause,
                                 out_item.tone_pulse, out_item.clear_exit));
        end else begin
          want = due_results.pop_front();
          if (out_item.mode_now !== want.mode_now ||
              out_item.change_cause !== want.change_cause ||
              out_item.tone_pulse !== want.tone_pulse ||
              out_item.clear_exit !== want.clear_exit)
            note_failure($sformatf(
              {"mismatch at cycle %0d: exp mode=%0d cause=%0d tone=%0d clr=%0d, ",
               "got mode=%0d cause=%0d tone=%0d clr=%0d"},
              cycles, want.mode_now, want.change_cause, want.tone_pulse, want.clear_exit,
              out_item.mode_now, out_item.change_cause, out_item.tone_pulse,
              out_item.clear_exit));
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("touch_gesture_mode_controller_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int start;
    int pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: swipe into settings, close, ignored close, movement cancel,
    // field extremes, timestamp wrap and zero time
    push_sample(1'b1, 1'b1, 10, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 90, 0, 0, 50, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 90, 0, 0, 10, 1'b0, 1'b0, 1'b1);
    push_sample(1'b0, 1'b0, 0, 0, 0, 10, 1'b0, 1'b0, 1'b1);
    push_sample(1'b1, 1'b1, -2048, 26, 0, 10, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 2047, 0, -26, 10, 1'b0, 1'b0, 1'b0);
    t_ms = 32'hFFFF_FFFE;
    push_sample(1'b1, 1'b0, 0, -2048, 2047, 1, 1'b0, 1'b1, 1'b0);
    push_sample(1'b0, 1'b0, 0, 0, 0, 1, 1'b1, 1'b1, 1'b0);
    drain();

    // Short hold and idle timeout: bridged dropout, activity, idle exit,
    // long press over a swipe start, remote exit, press across time wrap
    apply_setting(200, 100, 300, TOP_BAND_RST, SWIPE_MIN_DROP_RST, SWIPE_MAX_TIME_RST,
                  MOVE_CANCEL_RST);
    t_ms = 32'd1000;
    push_sample(1'b1, 1'b1, 600, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 600, 3, -3, 100, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 1'b0, 600, 0, 0, 50, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 600, 0, 0, 50, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 600, 0, 0, 100, 1'b0, 1'b1, 1'b0);
    push_sample(1'b0, 1'b0, 0, 0, 0, 400, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b1, 20, 0, 0, 300, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 20, 0, 0, 200, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 20, 0, 0, 50, 1'b1, 1'b0, 1'b1);
    push_sample(1'b0, 1'b0, 0, 0, 0, 50, 1'b0, 1'b0, 1'b0);
    t_ms = 32'hFFFF_FFA0;
    push_sample(1'b1, 1'b1, 700, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 700, 0, 0, 100, 1'b0, 1'b0, 1'b0);
    push_sample(1'b1, 1'b0, 700, 0, 0, 100, 1'b0, 1'b0, 1'b0);
    push_sample(1'b0, 1'b0, 0, 0, 0, 400, 1'b0, 1'b0, 1'b0);
    drain();

    // Random phases: a new setting and idling pattern each time
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 1) begin
        apply_setting(0, 0, 0, 0, 0, 0, 0);
      end else if (phase == 5) begin
        apply_setting(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 11'h7FF, 11'h7FF, 16'hFFFF, 11'h7FF);
      end else if (phase == 7) begin
        apply_setting(HOLD_TIME_RST, SLACK_TIME_RST, IDLE_TIMEOUT_RST, TOP_BAND_RST,
                      SWIPE_MIN_DROP_RST, SWIPE_MAX_TIME_RST, MOVE_CANCEL_RST);
      end else begin
        apply_setting($urandom_range(50, 400), $urandom_range(20, 150),
                      $urandom_range(200, 3000), $urandom_range(20, 200),
                      $urandom_range(10, 120), $urandom_range(100, 1000),
                      $urandom_range(5, 60));
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      // back the block up while the sender keeps offering
      if (phase == 2 || phase == 4) hold_asked++;
      start = n_queued;
      while (n_queued - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) gen_long_press();
        else if (pick < 65) gen_swipe();
        else if (pick < 80) gen_idle();
        else gen_noise();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("touch_gesture_mode_controller_tb: PASS");
    end else begin
      $display("touch_gesture_mode_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
